FILE: hw/rtl/line_follow_pd_steering_defines.svh
// ----------------------------------------------------------------------------
// line_follow_pd_steering_defines
// Assertion macros for the line follower steering block.
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOW_PD_STEERING_DEFINES_SVH
`define LINE_FOLLOW_PD_STEERING_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LFPD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lfpd check failed");

// next-cycle implication, sampled on clk, off during reset
`define LFPD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lfpd check failed");

`endif

FILE: hw/rtl/lfpd_pkg.sv
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared widths, register indexes, reset values and FSM type.
// ----------------------------------------------------------------------------
`default_nettype none

package lfpd_pkg;

	localparam int SENS_W = 6;
	localparam int IN_W   = 8;
	localparam int GAIN_W = 16;
	localparam int OUT_W  = 16;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 2;

	localparam logic [IDX_W-1:0] REG_GAIN_P     = 2'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_D     = 2'd1;
	localparam logic [IDX_W-1:0] REG_BASE_SPEED = 2'd2;

	localparam logic [GAIN_W-1:0]        GAIN_P_RST     = 16'd1150;
	localparam logic signed [GAIN_W-1:0] GAIN_D_RST     = 16'sd0;
	localparam logic signed [OUT_W-1:0]  BASE_SPEED_RST = 16'sd1200;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_MUL,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/line_follow_pd_steering.sv
// ----------------------------------------------------------------------------
// line_follow_pd_steering
// Line follower PD steering: sensor beat in, wheel targets and correction out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one sensor beat, sensor_bits in s_tdata[5:0]. m_* returns one
//   beat per input: left_target, right_target, correction (16-bit signed).
//   cfg_we/cfg_idx/cfg_data write gain_p (0), gain_d (1), base_speed (2);
//   other indexes are dropped. Write only while no beat is in flight.
// Timing:
//   One item at a time. After the input beat updates the error come a load,
//   16 steps of the bit-serial PD multiplier (one gain bit per cycle), a done
//   handoff, then scale, saturate and the output register. s_tready is high
//   again on the cycle after the result is loaded, so the next item can start
//   while the previous result still waits.
// Reset:
//   arst_n clears the line error, gains to 1150/0, base speed to 1200,
//   and empties the output register.
// Backpressure:
//   With m_tready low the result is held in m_tdata; a finished second
//   result waits inside the block and no third beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "line_follow_pd_steering_defines.svh"

module line_follow_pd_steering #(
	parameter int ERROR_FRAC_BITS = 12
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [lfpd_pkg::IN_W-1:0]         s_tdata,   // [5:0] sensor_bits, [7:6] zero
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [3*lfpd_pkg::OUT_W-1:0]           m_tdata,   // left_target, right_target, correction
	input  wire logic                              cfg_we,
	input  wire logic [lfpd_pkg::IDX_W-1:0]        cfg_idx,
	input  wire logic [lfpd_pkg::CFG_W-1:0]        cfg_data
);
	import lfpd_pkg::*;

	localparam int F   = ERROR_FRAC_BITS;
	localparam int EW  = F + 2;
	localparam int PW  = EW + 2 + GAIN_W;
	localparam int CFW = PW - F;
	localparam int SW  = OUT_W + 2;
	localparam logic signed [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	state_t state_q, state_d;

	logic [GAIN_W-1:0]        gain_p_q;
	logic signed [GAIN_W-1:0] gain_d_q;
	logic signed [OUT_W-1:0]  base_q;

	logic                     in_acc, mul_start, mul_done, load_out, m_tvalid_q;
	logic [3*OUT_W-1:0]       m_tdata_q;
	logic signed [EW-1:0]     err, prev;
	logic signed [PW-1:0]     pd;
	logic signed [CFW-1:0]    corr_full;
	logic signed [OUT_W-1:0]  corr, left_t, right_t;
	logic signed [SW-1:0]     corr_x, base_x, lt_full, rt_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= GAIN_P_RST;
			gain_d_q <= GAIN_D_RST;
			base_q   <= BASE_SPEED_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_GAIN_P:     gain_p_q <= cfg_data;
				REG_GAIN_D:     gain_d_q <= cfg_data;
				REG_BASE_SPEED: base_q   <= cfg_data;
				default:        ;
			endcase
		end
	end

	assign in_acc = s_tvalid && s_tready;

	lfpd_err #(
		.ERROR_FRAC_BITS(ERROR_FRAC_BITS)
	) u_err (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (in_acc),
		.sensor_bits (s_tdata[SENS_W-1:0]),
		.err         (err),
		.prev        (prev)
	);

	lfpd_smul #(
		.EW(EW)
	) u_smul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.gain_p (gain_p_q),
		.gain_d (gain_d_q),
		.err    (err),
		.prev   (prev),
		.done   (mul_done),
		.pd     (pd)
	);

	// floor shift, then saturate correction and both targets
	always_comb begin
		corr_full = pd[PW-1:F];
		if (corr_full[CFW-1:OUT_W-1] == {(CFW-OUT_W+1){corr_full[CFW-1]}})
			corr = corr_full[OUT_W-1:0];
		else
			corr = corr_full[CFW-1] ? SAT_MIN : SAT_MAX;
		corr_x  = {{2{corr[OUT_W-1]}}, corr};
		base_x  = {{2{base_q[OUT_W-1]}}, base_q};
		lt_full = -(base_x + corr_x);
		rt_full = corr_x - base_x;
		if (lt_full[SW-1:OUT_W-1] == {(SW-OUT_W+1){lt_full[SW-1]}})
			left_t = lt_full[OUT_W-1:0];
		else
			left_t = lt_full[SW-1] ? SAT_MIN : SAT_MAX;
		if (rt_full[SW-1:OUT_W-1] == {(SW-OUT_W+1){rt_full[SW-1]}})
			right_t = rt_full[OUT_W-1:0];
		else
			right_t = rt_full[SW-1] ? SAT_MIN : SAT_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		mul_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = ST_START;
			end
			ST_START: begin
				mul_start = 1'b1;
				state_d   = ST_MUL;
			end
			ST_MUL: begin
				if (mul_done)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (load_out)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out)
			m_tdata_q <= {corr, right_t, left_t};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`LFPD_ASSERT_NXT(a_acc_starts_mul, in_acc, state_q == ST_START)
	`LFPD_ASSERT_IMP(a_done_in_mul, mul_done, state_q == ST_MUL)
	`LFPD_ASSERT_NXT(a_stall_holds_fin, state_q == ST_FIN && m_tvalid && !m_tready,
		state_q == ST_FIN)

endmodule

`default_nettype wire

FILE: hw/rtl/lfpd_err.sv
// ----------------------------------------------------------------------------
// lfpd_err
// Sensor pattern decode and line error register (Q format, decay by 0.7).
// ----------------------------------------------------------------------------
`default_nettype none

module lfpd_err #(
	parameter int ERROR_FRAC_BITS = 12
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 load,
	input  wire logic [lfpd_pkg::SENS_W-1:0]          sensor_bits,
	output logic signed [ERROR_FRAC_BITS+1:0]         err,
	output logic signed [ERROR_FRAC_BITS+1:0]         prev
);
	import lfpd_pkg::*;

	localparam int F   = ERROR_FRAC_BITS;
	localparam int EW  = F + 2;
	localparam int ONE = 1 << F;
	localparam int MW  = EW + 3;
	localparam int RW  = EW + 4;
	localparam int S   = EW + 7;
	localparam int PW  = MW + RW;
	localparam longint unsigned RECIP = ((longint'(1) << S) + 9) / 10;
	localparam logic [RW-1:0]   RECIP_W = RW'(RECIP);

	localparam logic [SENS_W-1:0] PAT_C    = 6'b001100;
	localparam logic [SENS_W-1:0] PAT_R01  = 6'b011110;
	localparam logic [SENS_W-1:0] PAT_R02  = 6'b111100;
	localparam logic [SENS_W-1:0] PAT_R04  = 6'b111000;
	localparam logic [SENS_W-1:0] PAT_R09A = 6'b110000;
	localparam logic [SENS_W-1:0] PAT_R09B = 6'b100000;
	localparam logic [SENS_W-1:0] PAT_L01  = 6'b001111;
	localparam logic [SENS_W-1:0] PAT_L025 = 6'b000111;
	localparam logic [SENS_W-1:0] PAT_L03  = 6'b000011;
	localparam logic [SENS_W-1:0] PAT_L08  = 6'b000001;
	localparam logic [SENS_W-1:0] PAT_DARK = 6'b000000;

	localparam logic signed [EW-1:0] E_P01  = EW'((ONE + 5) / 10);
	localparam logic signed [EW-1:0] E_P02  = EW'((ONE + 2) / 5);
	localparam logic signed [EW-1:0] E_P04  = EW'((2 * ONE + 2) / 5);
	localparam logic signed [EW-1:0] E_P09  = EW'((9 * ONE + 5) / 10);
	localparam logic signed [EW-1:0] E_N01  = EW'(-((ONE + 5) / 10));
	localparam logic signed [EW-1:0] E_N025 = EW'(-((ONE + 2) / 4));
	localparam logic signed [EW-1:0] E_N03  = EW'(-((3 * ONE + 5) / 10));
	localparam logic signed [EW-1:0] E_N08  = EW'(-((4 * ONE + 2) / 5));

	logic signed [EW-1:0] err_q, prev_q, nxt, decay;
	logic [EW-1:0]        mag, quo;
	logic [MW-1:0]        m7;
	logic [PW-1:0]        prod;

	// |e|*7/10 truncated: reciprocal multiply, exact for this range
	always_comb begin
		mag   = err_q[EW-1] ? EW'(-err_q) : err_q;
		m7    = (MW'(mag) << 3) - MW'(mag);
		prod  = PW'(m7) * PW'(RECIP_W);
		quo   = prod[S +: EW];
		decay = err_q[EW-1] ? -$signed(quo) : $signed(quo);
		unique case (sensor_bits)
			PAT_C:    nxt = '0;
			PAT_R01:  nxt = E_P01;
			PAT_R02:  nxt = E_P02;
			PAT_R04:  nxt = E_P04;
			PAT_R09A: nxt = E_P09;
			PAT_R09B: nxt = E_P09;
			PAT_L01:  nxt = E_N01;
			PAT_L025: nxt = E_N025;
			PAT_L03:  nxt = E_N03;
			PAT_L08:  nxt = E_N08;
			PAT_DARK: nxt = err_q;
			default:  nxt = decay;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q  <= '0;
			prev_q <= '0;
		end else if (load) begin
			prev_q <= err_q;
			err_q  <= nxt;
		end
	end

	assign err  = err_q;
	assign prev = prev_q;

endmodule

`default_nettype wire

FILE: hw/rtl/lfpd_smul.sv
// ----------------------------------------------------------------------------
// lfpd_smul
// Bit-serial PD product: gain_p*e + gain_d*(e - prev), one gain bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lfpd_smul #(
	parameter int EW = 14
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	input  wire logic [lfpd_pkg::GAIN_W-1:0]            gain_p,
	input  wire logic signed [lfpd_pkg::GAIN_W-1:0]     gain_d,
	input  wire logic signed [EW-1:0]                   err,
	input  wire logic signed [EW-1:0]                   prev,
	output logic                                        done,
	output logic signed [EW+1+lfpd_pkg::GAIN_W:0]       pd
);
	import lfpd_pkg::*;

	localparam int DW = EW + 1;
	localparam int TW = EW + 2;
	localparam int CW = $clog2(GAIN_W);

	logic [GAIN_W-1:0]    gp_q, gd_q, lo_q;
	logic signed [EW-1:0] e_q;
	logic signed [DW-1:0] d_q;
	logic signed [TW-1:0] hi_q, add_p, add_d, sum, e_x, d_x;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q, done_q, last;

	// top gain_d bit carries weight -2^15
	always_comb begin
		last  = (cnt_q == CW'(GAIN_W - 1));
		e_x   = {{(TW-EW){e_q[EW-1]}}, e_q};
		d_x   = {{(TW-DW){d_q[DW-1]}}, d_q};
		add_p = gp_q[0] ? e_x : '0;
		add_d = gd_q[0] ? (last ? -d_x : d_x) : '0;
		sum   = hi_q + add_p + add_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			gp_q <= gain_p;
			gd_q <= gain_d;
			e_q  <= err;
			d_q  <= {err[EW-1], err} - {prev[EW-1], prev};
			hi_q <= '0;
		end else if (busy_q) begin
			gp_q <= gp_q >> 1;
			gd_q <= gd_q >> 1;
			hi_q <= sum >>> 1;
			lo_q <= {sum[0], lo_q[GAIN_W-1:1]};
		end
	end

	assign done = done_q;
	assign pd   = $signed({hi_q, lo_q});

endmodule

`default_nettype wire
